// ===== hw/rtl/stb_pkg.sv =====
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types, widths and helpers for the software timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TIMER_AW   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam int MODE_W     = 2;
    localparam int IDX_W      = 4;
    localparam int MS_W       = 32;
    localparam int TICKS_W    = 32;
    localparam int MULT_W     = 16;
    localparam int PROD_W     = MULT_W + MS_W;
    localparam int TICK_SHIFT = 10;          // divide by 1024
    localparam int QUOT_W     = PROD_W - TICK_SHIFT;

    localparam logic [MULT_W-1:0] TICKS_MULT_RST = MULT_W'(1024);

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;
    localparam logic STAT_OK     = 1'b0;
    localparam logic STAT_ERR    = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 2'd0,
        MODE_CREATE = 2'd1,
        MODE_START  = 2'd2,
        MODE_STOP   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMD,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // product / 1024, saturated to the tick width, never zero
    function automatic logic [TICKS_W-1:0] duration_ticks(input logic [PROD_W-1:0] prod);
        logic [QUOT_W-1:0] q;
        logic [TICKS_W-1:0] res;
        q = prod[PROD_W-1:TICK_SHIFT];
        if (|q[QUOT_W-1:TICKS_W]) begin
            res = '1;
        end else if (q[TICKS_W-1:0] == '0) begin
            res = TICKS_W'(1);
        end else begin
            res = q[TICKS_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/stb_in_if.sv =====
// ----------------------------------------------------------------------------
// stb_in_if
// Command channel of the timer bank: valid/ready with the command payload.
// ----------------------------------------------------------------------------
interface stb_in_if;
    import stb_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [IDX_W-1:0]   timer_index;
    logic               periodic;
    logic [MS_W-1:0]    millisec;

    modport source (output valid, output mode, output timer_index, output periodic,
                    output millisec, input ready);
    modport sink   (input valid, input mode, input timer_index, input periodic,
                    input millisec, output ready);
endinterface

// ===== hw/rtl/stb_out_if.sv =====
// ----------------------------------------------------------------------------
// stb_out_if
// Result channel of the timer bank: valid/ready with status and expiry beats.
// ----------------------------------------------------------------------------
interface stb_out_if;
    import stb_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [IDX_W-1:0]    expired_index;
    logic                status;
    logic [TICKS_W-1:0]  time_now;
    logic                last;

    modport source (output valid, output kind, output expired_index, output status,
                    output time_now, output last, input ready);
    modport sink   (input valid, input kind, input expired_index, input status,
                    input time_now, input last, output ready);
endinterface

// ===== hw/rtl/software_timer_bank.sv =====
// ----------------------------------------------------------------------------
// software_timer_bank
// Bank of down-counting one-shot / periodic timers advanced by tick commands.
// ----------------------------------------------------------------------------
// Command (create/start/stop): accepted and latched; in ST_CMD the status
//   beat is registered once the output register is free.
// Tick: accepted in ST_IDLE, then ST_SCAN takes one timer entry (16) per
//   cycle while the counter RAMs are read, decremented and written back;
//   then ST_FLUSH if a beat is still held. Output back-pressure adds stalls.
// Reset (sync, active low): no timer created, tick count 0, ticks_mult 1024.
//   Created flags are flip-flops, so the RAMs need no clearing pass.
// ----------------------------------------------------------------------------
module software_timer_bank (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [stb_pkg::MULT_W-1:0]    i_cfg_wdata,
    stb_in_if.sink                        i_cmd,
    stb_out_if.source                     o_evt
);
    import stb_pkg::*;

    t_state                 r_state, n_state;
    logic [MULT_W-1:0]      r_ticks_mult;
    logic [TICKS_W-1:0]     r_tick_count, n_tick_count;
    logic [NUM_TIMERS-1:0]  r_in_use, n_in_use;
    logic [NUM_TIMERS-1:0]  r_is_per, n_is_per;

    // latched command
    t_mode                  r_mode;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_per;
    logic [PROD_W-1:0]      r_prod;

    // scan pointer and the held expiry beat
    logic [TIMER_AW-1:0]    r_ptr, n_ptr;
    logic                   r_pend_valid, n_pend_valid;
    logic [IDX_W-1:0]       r_pend_idx, n_pend_idx;

    // output register
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_kind, n_out_kind;
    logic [IDX_W-1:0]       r_out_idx, n_out_idx;
    logic                   r_out_status, n_out_status;
    logic [TICKS_W-1:0]     r_out_time, n_out_time;
    logic                   r_out_last, n_out_last;

    // RAM ports
    logic                   rem_we, per_we, ram_re;
    logic [TIMER_AW-1:0]    ram_waddr, ram_raddr;
    logic [TICKS_W-1:0]     rem_wdata, per_wdata, rem_rdata, per_rdata;

    logic                   in_ready, in_accept, out_free;
    logic                   idx_ok, cmd_status;
    logic [TIMER_AW-1:0]    cmd_addr;
    logic                   ent_active, ent_expire, scan_stall, scan_last;
    logic [TICKS_W-1:0]     rem_dec;

    stb_ram #(.WIDTH(TICKS_W), .DEPTH(NUM_TIMERS)) u_rem_ram (
        .i_clk   (i_clk),
        .i_we    (rem_we),
        .i_waddr (ram_waddr),
        .i_wdata (rem_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rem_rdata)
    );

    stb_ram #(.WIDTH(TICKS_W), .DEPTH(NUM_TIMERS)) u_per_ram (
        .i_clk   (i_clk),
        .i_we    (per_we),
        .i_waddr (ram_waddr),
        .i_wdata (per_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (per_rdata)
    );

    assign in_ready  = (r_state == ST_IDLE);
    assign in_accept = i_cmd.valid && in_ready;
    assign out_free  = !r_out_valid || o_evt.ready;

    assign idx_ok     = (int'(r_idx) < NUM_TIMERS);
    assign cmd_addr   = TIMER_AW'(r_idx);
    assign cmd_status = (!idx_ok || (r_mode != MODE_CREATE && !r_in_use[cmd_addr]))
                        ? STAT_ERR : STAT_OK;

    assign ent_active = r_in_use[r_ptr] && (rem_rdata != '0);
    assign rem_dec    = rem_rdata - TICKS_W'(1);
    assign ent_expire = ent_active && (rem_dec == '0);
    // a new expiry can only replace the held one once the output register can take it
    assign scan_stall = ent_expire && r_pend_valid && !out_free;
    assign scan_last  = (r_ptr == TIMER_AW'(NUM_TIMERS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = (t_mode'(i_cmd.mode) == MODE_TICK) ? ST_SCAN : ST_CMD;
                end
            end
            ST_CMD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!scan_stall && scan_last) begin
                    n_state = (ent_expire || r_pend_valid) ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_tick_count = r_tick_count;
        n_in_use     = r_in_use;
        n_is_per     = r_is_per;
        n_ptr        = r_ptr;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;

        n_out_valid  = r_out_valid && !o_evt.ready;
        n_out_kind   = r_out_kind;
        n_out_idx    = r_out_idx;
        n_out_status = r_out_status;
        n_out_time   = r_out_time;
        n_out_last   = r_out_last;

        rem_we    = 1'b0;
        per_we    = 1'b0;
        rem_wdata = '0;
        per_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        ram_waddr = cmd_addr;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && t_mode'(i_cmd.mode) == MODE_TICK) begin
                    n_tick_count = r_tick_count + TICKS_W'(1);
                    ram_re       = 1'b1;
                    ram_raddr    = '0;
                    n_ptr        = '0;
                    n_pend_valid = 1'b0;
                end
            end
            ST_CMD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_STATUS;
                    n_out_idx    = r_idx;
                    n_out_status = cmd_status;
                    n_out_time   = r_tick_count;
                    n_out_last   = 1'b1;
                    if (cmd_status == STAT_OK) begin
                        unique case (r_mode)
                            MODE_CREATE: begin
                                n_in_use[cmd_addr] = 1'b1;
                                n_is_per[cmd_addr] = r_per;
                                rem_we = 1'b1;
                                per_we = 1'b1;
                            end
                            MODE_START: begin
                                rem_we    = 1'b1;
                                per_we    = 1'b1;
                                rem_wdata = duration_ticks(r_prod);
                                per_wdata = duration_ticks(r_prod);
                            end
                            MODE_STOP: begin
                                rem_we = 1'b1;
                            end
                            MODE_TICK: begin
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            ST_SCAN: begin
                ram_waddr = r_ptr;
                if (!scan_stall) begin
                    if (ent_active) begin
                        rem_we    = 1'b1;
                        rem_wdata = (ent_expire && r_is_per[r_ptr]) ? per_rdata : rem_dec;
                    end
                    if (ent_expire) begin
                        // held beat is not the last one: a later expiry follows
                        if (r_pend_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_kind   = KIND_EXPIRY;
                            n_out_idx    = r_pend_idx;
                            n_out_status = STAT_OK;
                            n_out_time   = r_tick_count;
                            n_out_last   = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_idx   = IDX_W'(r_ptr);
                    end
                    if (!scan_last) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_ptr + TIMER_AW'(1);
                        n_ptr     = r_ptr + TIMER_AW'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_EXPIRY;
                    n_out_idx    = r_pend_idx;
                    n_out_status = STAT_OK;
                    n_out_time   = r_tick_count;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ticks_mult <= TICKS_MULT_RST;
            r_tick_count <= '0;
            r_in_use     <= '0;
            r_is_per     <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tick_count <= n_tick_count;
            r_in_use     <= n_in_use;
            r_is_per     <= n_is_per;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_ticks_mult <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode <= t_mode'(i_cmd.mode);
            r_idx  <= i_cmd.timer_index;
            r_per  <= i_cmd.periodic;
            r_prod <= PROD_W'(r_ticks_mult) * PROD_W'(i_cmd.millisec);
        end
        r_ptr        <= n_ptr;
        r_pend_idx   <= n_pend_idx;
        r_out_kind   <= n_out_kind;
        r_out_idx    <= n_out_idx;
        r_out_status <= n_out_status;
        r_out_time   <= n_out_time;
        r_out_last   <= n_out_last;
    end

    assign i_cmd.ready         = in_ready;
    assign o_evt.valid         = r_out_valid;
    assign o_evt.kind          = r_out_kind;
    assign o_evt.expired_index = r_out_idx;
    assign o_evt.status        = r_out_status;
    assign o_evt.time_now      = r_out_time;
    assign o_evt.last          = r_out_last;
endmodule

// ===== hw/rtl/stb_ram.sv =====
// ----------------------------------------------------------------------------
// stb_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module stb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for software_timer_bank. A directed table covers error
// paths, re-create, duration floor and saturation, then random create/start/
// stop/tick traffic runs under several ticks_mult values. Every result beat
// is checked against a bank model kept in the bench.
// ----------------------------------------------------------------------------
module tb;
    import stb_pkg::*;

    localparam int LIMIT_CYC = 200000;
    localparam int IDLE_WAIT = 24;     // covers a full tick scan plus held beat
    localparam int DRAIN_CYC = 40;
    localparam int PHASE_ITEMS = 16;
    localparam int NUM_PHASES = 5;
    localparam int HOLD_AFTER = 30;    // command beats before the long stall
    localparam int HOLD_CYC = 300;

    typedef struct packed {
        logic                kind;
        logic [IDX_W-1:0]    idx;
        logic                status;
        logic [TICKS_W-1:0]  time_now;
        logic                last;
    } t_evt;

    typedef struct packed {
        t_mode               mode;
        logic [IDX_W-1:0]    idx;
        logic                periodic;
        logic [MS_W-1:0]     ms;
    } t_cmd;

    typedef enum logic {ROW_CMD, ROW_CFG} t_row_kind;

    // for ROW_CFG rows the low bits of cmd.ms carry the ticks_mult value
    typedef struct packed {
        t_row_kind  rk;
        t_cmd       cmd;
        logic       has_exp;
        t_evt       exp;
    } t_row;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE} t_rx_mode;

    localparam t_evt NO_EXP = '0;
    localparam t_cmd NOP    = '{MODE_TICK, 4'd0, 1'b0, 32'd0};

    localparam t_row DIR_TAB [25] = '{
        '{ROW_CMD, '{MODE_START,  4'd0,  1'b0, 32'd5}, 1'b1,
          '{KIND_STATUS, 4'd0, STAT_ERR, 32'd0, 1'b1}},
        '{ROW_CMD, '{MODE_STOP,   4'd15, 1'b0, 32'd0}, 1'b1,
          '{KIND_STATUS, 4'd15, STAT_ERR, 32'd0, 1'b1}},
        '{ROW_CMD, '{MODE_TICK,   4'd0,  1'b0, 32'd0}, 1'b0, NO_EXP},
        '{ROW_CMD, '{MODE_CREATE, 4'd0,  1'b1, 32'd0}, 1'b1,
          '{KIND_STATUS, 4'd0, STAT_OK, 32'd1, 1'b1}},
        '{ROW_CMD, '{MODE_CREATE, 4'd15, 1'b0, 32'd0}, 1'b1,
          '{KIND_STATUS, 4'd15, STAT_OK, 32'd1, 1'b1}},
        '{ROW_CMD, '{MODE_START,  4'd0,  1'b0, 32'd0}, 1'b0, NO_EXP},
        '{ROW_CMD, '{MODE_START,  4'd15, 1'b0, 32'd2}, 1'b0, NO_EXP},
        '{ROW_CMD, '{MODE_TICK,   4'd0,  1'b0, 32'd0}, 1'b0, NO_EXP},
        '{ROW_CMD, '{MODE_TICK,   4'd0,  1'b0, 32'd0}, 1'b0, NO_EXP},
        '{ROW_CMD, '{MODE_STOP,   4'd0,  1'b0, 32'd0}, 1'b0, NO_EXP},
        '{ROW_CMD, '{MODE_TICK,   4'd0,  1'b0, 32'd0}, 1'b0, NO_EXP},
        '{ROW_CMD, '{MODE_CREATE, 4'd0,  1'b0, 32'd0}, 1'b1,
          '{KIND_STATUS, 4'd0, STAT_OK, 32'd4, 1'b1}},
        '{ROW_CMD, '{MODE_START,  4'd3,  1'b0, 32'hFFFF_FFFF}, 1'b1,
          '{KIND_STATUS, 4'd3, STAT_ERR, 32'd4, 1'b1}},
        '{ROW_CFG, '{MODE_TICK,   4'd0,  1'b0, 32'd0}, 1'b0, NO_EXP},
        '{ROW_CMD, '{MODE_CREATE, 4'd3,  1'b1, 32'd0}, 1'b0, NO_EXP},
        '{ROW_CMD, '{MODE_START,  4'd3,  1'b0, 32'hFFFF_FFFF}, 1'b0, NO_EXP},
        '{ROW_CFG, '{MODE_TICK,   4'd0,  1'b0, 32'd65535}, 1'b0, NO_EXP},
        '{ROW_CMD, '{MODE_START,  4'd0,  1'b0, 32'hFFFF_FFFF}, 1'b0, NO_EXP},
        '{ROW_CMD, '{MODE_START,  4'd15, 1'b0, 32'd17}, 1'b0, NO_EXP},
        '{ROW_CMD, '{MODE_TICK,   4'd0,  1'b0, 32'd0}, 1'b0, NO_EXP},
        '{ROW_CFG, '{MODE_TICK,   4'd0,  1'b0, 32'd1}, 1'b0, NO_EXP},
        '{ROW_CMD, '{MODE_START,  4'd15, 1'b0, 32'd1}, 1'b0, NO_EXP},
        '{ROW_CMD, '{MODE_TICK,   4'd0,  1'b0, 32'd0}, 1'b0, NO_EXP},
        '{ROW_CMD, '{MODE_STOP,   4'd3,  1'b0, 32'd0}, 1'b0, NO_EXP},
        '{ROW_CMD, '{MODE_TICK,   4'd0,  1'b0, 32'd0}, 1'b0, NO_EXP}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [MULT_W-1:0] i_cfg_wdata;

    stb_in_if  cmd_if ();
    stb_out_if evt_if ();

    software_timer_bank dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_if),
        .o_evt       (evt_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // bank model
    logic [TICKS_W-1:0] bank_rem    [NUM_TIMERS];
    logic [TICKS_W-1:0] bank_period [NUM_TIMERS];
    logic               bank_per    [NUM_TIMERS];
    logic               bank_used   [NUM_TIMERS];
    logic [TICKS_W-1:0] bank_ticks  = '0;
    logic [MULT_W-1:0]  bank_mult   = TICKS_MULT_RST;

    t_evt evt_exp_q [$];

    int  cmd_beats  = 0;
    int  mismatches = 0;
    int  cyc        = 0;
    int  burst_left = 0;
    bit  gaps_on    = 1'b1;
    logic rx_hold   = 1'b0;
    t_rx_mode rx_mode = RX_OPEN;
    int  rx_cyc     = 0;

    initial begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            bank_rem[i]    = '0;
            bank_period[i] = '0;
            bank_per[i]    = 1'b0;
            bank_used[i]   = 1'b0;
        end
    end

    function automatic logic [TICKS_W-1:0] start_ticks(input logic [MS_W-1:0] ms);
        logic [MULT_W+MS_W-1:0] prod;
        logic [MULT_W+MS_W-1:0] quot;
        prod = {{MS_W{1'b0}}, bank_mult} * {{MULT_W{1'b0}}, ms};
        quot = prod / 1024;
        if (quot > {{MULT_W{1'b0}}, {TICKS_W{1'b1}}})
            return '1;
        else if (quot == '0)
            return TICKS_W'(1);
        return quot[TICKS_W-1:0];
    endfunction

    task automatic predict_bank(input t_cmd c);
        t_evt e;
        int   n;
        n = 0;
        if (c.mode == MODE_TICK) begin
            bank_ticks = bank_ticks + TICKS_W'(1);
            for (int i = 0; i < NUM_TIMERS; i++) begin
                if (bank_used[i] && bank_rem[i] != '0) begin
                    bank_rem[i] = bank_rem[i] - TICKS_W'(1);
                    if (bank_rem[i] == '0) begin
                        evt_exp_q.push_back('{KIND_EXPIRY, IDX_W'(i), STAT_OK,
                                              bank_ticks, 1'b0});
                        n++;
                        if (bank_per[i])
                            bank_rem[i] = bank_period[i];
                    end
                end
            end
            if (n > 0) begin
                e = evt_exp_q.pop_back();
                e.last = 1'b1;
                evt_exp_q.push_back(e);
            end
        end else begin
            e = '{KIND_STATUS, c.idx, STAT_OK, bank_ticks, 1'b1};
            if (c.mode == MODE_CREATE) begin
                bank_used[c.idx]   = 1'b1;
                bank_per[c.idx]    = c.periodic;
                bank_rem[c.idx]    = '0;
                bank_period[c.idx] = '0;
            end else if (!bank_used[c.idx]) begin
                e.status = STAT_ERR;
            end else if (c.mode == MODE_START) begin
                bank_period[c.idx] = start_ticks(c.ms);
                bank_rem[c.idx]    = bank_period[c.idx];
            end else begin
                bank_rem[c.idx] = '0;
            end
            evt_exp_q.push_back(e);
        end
    endtask

    function automatic t_cmd mk_cmd(input t_mode m, input int idx, input logic per,
                                    input logic [MS_W-1:0] ms);
        return '{m, IDX_W'(idx), per, ms};
    endfunction

    // ms that gives roughly d ticks at the current ticks_mult
    function automatic logic [MS_W-1:0] short_ms(input int d);
        if (bank_mult == '0)
            return $urandom;
        return MS_W'((d * 1024) / bank_mult);
    endfunction

    task automatic put_cmd(input t_cmd c, output int pushed);
        int n0;
        cmd_if.valid       <= 1'b1;
        cmd_if.mode        <= c.mode;
        cmd_if.timer_index <= c.idx;
        cmd_if.periodic    <= c.periodic;
        cmd_if.millisec    <= c.ms;
        @(posedge i_clk);
        while (!cmd_if.ready)
            @(posedge i_clk);
        cmd_beats++;
        n0 = evt_exp_q.size();
        predict_bank(c);
        pushed = evt_exp_q.size() - n0;
    endtask

    task automatic send(input t_cmd c, input logic has_exp, input t_evt e);
        int pushed;
        int gap;
        put_cmd(c, pushed);
        if (has_exp) begin
            repeat (pushed) void'(evt_exp_q.pop_back());
            evt_exp_q.push_back(e);
        end
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 12);
                cmd_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic write_mult(input logic [MULT_W-1:0] v);
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (evt_exp_q.size() != 0)
            @(posedge i_clk);
        // a tick without expiries may still be scanning
        repeat (IDLE_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        bank_mult = v;
    endtask

    // maybe create, then start one timer, maybe stop it, then run 1 to 5 ticks
    task automatic run_one_timer();
        int idx;
        int d;
        int nt;
        idx = $urandom_range(0, NUM_TIMERS - 1);
        d   = $urandom_range(1, 4);
        nt  = $urandom_range(1, 5);
        if ($urandom_range(0, 3) != 0)
            send(mk_cmd(MODE_CREATE, idx, 1'($urandom_range(0, 1)), $urandom),
                 1'b0, NO_EXP);
        send(mk_cmd(MODE_START, idx, 1'($urandom_range(0, 1)), short_ms(d)),
             1'b0, NO_EXP);
        if ($urandom_range(0, 4) == 0)
            send(mk_cmd(MODE_STOP, idx, 1'b0, $urandom), 1'b0, NO_EXP);
        repeat (nt) send(NOP, 1'b0, NO_EXP);
    endtask

    task automatic note_bad(input string what, input t_evt g, input t_evt w);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t %s: got kind=%0d idx=%0d st=%0d t=%0h last=%0d,",
                      " want kind=%0d idx=%0d st=%0d t=%0h last=%0d"},
                     $time, what, g.kind, g.idx, g.status, g.time_now, g.last,
                     w.kind, w.idx, w.status, w.time_now, w.last);
    endtask

    always @(posedge i_clk) begin
        t_evt got;
        t_evt want;
        if (i_rst_n && evt_if.valid && evt_if.ready) begin
            got = '{evt_if.kind, evt_if.expired_index, evt_if.status,
                    evt_if.time_now, evt_if.last};
            if (evt_exp_q.size() == 0) begin
                note_bad("unexpected beat", got, NO_EXP);
            end else begin
                want = evt_exp_q.pop_front();
                if (got.kind !== want.kind || got.idx !== want.idx ||
                    got.status !== want.status || got.time_now !== want.time_now ||
                    got.last !== want.last)
                    note_bad("beat mismatch", got, want);
            end
        end
    end

    // result side: stall pattern is chosen anew each time rx_cyc runs down to zero
    always @(posedge i_clk) begin
        if (rx_cyc == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_cyc  = 63;
        end else begin
            rx_cyc--;
        end
        case (rx_mode)
            RX_OPEN:   evt_if.ready <= !rx_hold;
            RX_COIN:   evt_if.ready <= !rx_hold && ($urandom_range(0, 1) == 1);
            default:   evt_if.ready <= !rx_hold && (rx_cyc % 4 == 0);
        endcase
    end

    // long stall on the result side so the bank backs up into the command port
    initial begin
        @(posedge i_clk);
        while (cmd_beats < HOLD_AFTER)
            @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT_CYC) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int ph0;
        logic [MULT_W-1:0] m;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_wdata        <= '0;
        cmd_if.valid       <= 1'b0;
        cmd_if.mode        <= MODE_TICK;
        cmd_if.timer_index <= '0;
        cmd_if.periodic    <= 1'b0;
        cmd_if.millisec    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_TAB[r]) begin
            if (DIR_TAB[r].rk == ROW_CFG)
                write_mult(DIR_TAB[r].cmd.ms[MULT_W-1:0]);
            else
                send(DIR_TAB[r].cmd, DIR_TAB[r].has_exp, DIR_TAB[r].exp);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       m = TICKS_MULT_RST;
                1:       m = '1;
                2:       m = '0;
                3:       m = MULT_W'($urandom_range(1, 65535));
                default: m = MULT_W'(2048);
            endcase
            write_mult(m);
            gaps_on = (p != 2);
            ph0 = cmd_beats;
            if (p == 0) begin
                // every timer expires on the same tick, max beats per item
                for (int i = 0; i < NUM_TIMERS; i++)
                    send(mk_cmd(MODE_CREATE, i, 1'($urandom_range(0, 1)), 32'd0),
                         1'b0, NO_EXP);
                for (int i = 0; i < NUM_TIMERS; i++)
                    send(mk_cmd(MODE_START, i, 1'b0, 32'd0), 1'b0, NO_EXP);
                send(NOP, 1'b0, NO_EXP);
                send(NOP, 1'b0, NO_EXP);
            end
            while (cmd_beats - ph0 < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 6)
                    run_one_timer();
                else
                    send(mk_cmd(t_mode'($urandom_range(0, 3)),
                                $urandom_range(0, NUM_TIMERS - 1),
                                1'($urandom_range(0, 1)), $urandom), 1'b0, NO_EXP);
            end
        end

        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (evt_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
